### hw/rtl/tbpt_pkg.sv
// shared types, widths and constants of the tait-bryan pose to transform block
// no dependencies; every other file of the block imports this package
package tbpt_pkg;

  // fixed field widths of the stream words
  localparam int ANGLE_W  = 16;
  localparam int SHIFT_W  = 32;
  localparam int ENTRY_W  = 16;
  localparam int N_ENTRY  = 9;
  localparam int OUT_FRAC = 14;
  localparam int ENTRY_MAX = 1 << OUT_FRAC;

  // packed word widths, both already whole bytes
  localparam int IN_W  = 3 * ANGLE_W + 3 * SHIFT_W;
  localparam int OUT_W = N_ENTRY * ENTRY_W + 3 * SHIFT_W;

  // defaults for the top level parameters
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // cordic datapath: 32-bit phase, q30 vector
  localparam int CW              = 32;
  localparam int CORDIC_STEPS    = 30;
  localparam int CORDIC_GAIN_Q30 = 652032874;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [CW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // translation, x in the lowest bits
  typedef struct packed {
    logic [SHIFT_W-1:0] z;
    logic [SHIFT_W-1:0] y;
    logic [SHIFT_W-1:0] x;
  } shifts_t;

  // one result word, laid out exactly as m_axis_tdata
  typedef struct packed {
    shifts_t                         shf;
    logic [N_ENTRY-1:0][ENTRY_W-1:0] ent;
  } result_t;

endpackage

### hw/rtl/tait_bryan_pose_to_transform_unit.sv
// top level of the tait-bryan pose to transform block
// instantiates tbpt_cordic, tbpt_matrix and tbpt_skid; uses tbpt_pkg
//
// usage:
// s_axis carries one pose per word: angle_x, angle_y, angle_z (binary angles,
// one turn per 2^ANGLE_BITS units) then shift_x, shift_y, shift_z (q16.16).
// m_axis carries one transform per word: the nine rotation entries in q1.14,
// column by column, then the translation unchanged.
// the rate is one word per cycle unless the receiver stalls, set by the cordic
// pipeline of one iteration per stage and the five matrix stages behind it.
// there is no state across words; reset empties every stage and the output.
// when the receiver stalls, the output register holds its word and one more
// word drops into the skid stage; only then does the whole pipeline freeze
// and s_axis_tready go low, so nothing is lost or repeated.
module tait_bryan_pose_to_transform_unit
  import tbpt_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // angle_x, angle_y, angle_z, shift_x, shift_y, shift_z
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // r_row0_col0, r_row1_col0, r_row2_col0, r_row0_col1, r_row1_col1,
  // r_row2_col1, r_row0_col2, r_row1_col2, r_row2_col2,
  // out_shift_x, out_shift_y, out_shift_z
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int TW = FRAC_BITS + 2;

  logic                    en;
  logic                    cor_vld, mat_vld;
  logic [2:0][ANGLE_W-1:0] angles;
  shifts_t                 in_shf, cor_shf;
  logic [2:0][TW-1:0]      sin_v, cos_v;
  result_t                 mat_res, m_res;

  // unpack the input word
  assign angles = s_axis_tdata[3*ANGLE_W-1:0];
  assign in_shf = shifts_t'(s_axis_tdata[IN_W-1:3*ANGLE_W]);

  tbpt_cordic #(
    .ANGLE_BITS(ANGLE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .angle_i(angles),
    .shf_i  (in_shf),
    .vld_o  (cor_vld),
    .sin_o  (sin_v),
    .cos_o  (cos_v),
    .shf_o  (cor_shf)
  );

  tbpt_matrix #(
    .FRAC_BITS(FRAC_BITS)
  ) u_matrix (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (cor_vld),
    .sin_i (sin_v),
    .cos_i (cos_v),
    .shf_i (cor_shf),
    .vld_o (mat_vld),
    .res_o (mat_res)
  );

  tbpt_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (mat_vld),
    .res_i  (mat_res),
    .en_o   (en),
    .m_vld_o(m_axis_tvalid),
    .m_res_o(m_res),
    .m_rdy_i(m_axis_tready)
  );

  assign s_axis_tready = en;
  assign m_axis_tdata  = m_res;

  // a frozen pipeline always has a word waiting at the output
  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("pipeline frozen with no word at the output");

  // a ready receiver drains the skid stage, so the input is ready in the next cycle
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |=> s_axis_tready)
    else $error("skid stage not drained after a ready cycle");

  // saturation keeps the entries within plus or minus one
  a_sat_sy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_res.ent[6]) <= ENTRY_MAX) &&
                      ($signed(m_res.ent[6]) >= -ENTRY_MAX))
    else $error("entry r_row0_col2 outside plus or minus one");

  a_sat_r11: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_res.ent[4]) <= ENTRY_MAX) &&
                      ($signed(m_res.ent[4]) >= -ENTRY_MAX))
    else $error("entry r_row1_col1 outside plus or minus one");

endmodule

### hw/rtl/tbpt_cordic.sv
// pipelined cordic for the three angles: phase set-up, one iteration per stage,
// then negate, round and clamp to sine and cosine; uses tbpt_pkg
module tbpt_cordic
  import tbpt_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int TW = FRAC_BITS + 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [2:0][ANGLE_W-1:0] angle_i,
  input  shifts_t                 shf_i,
  output logic                    vld_o,
  output logic [2:0][TW-1:0]      sin_o,
  output logic [2:0][TW-1:0]      cos_o,
  output shifts_t                 shf_o
);

  localparam int L  = CORDIC_STEPS - 1;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [CW:0] ONE  = 1;
  localparam logic signed [CW:0] HALF = (ONE <<< SH) >>> 1;
  localparam logic signed [CW:0] LIM  = ONE <<< FRAC_BITS;

  function automatic logic [TW-1:0] clamp_trig(logic signed [CW:0] v);
    logic signed [CW:0] r;
    if (v > LIM) begin
      r = LIM;
    end else if (v < -LIM) begin
      r = -LIM;
    end else begin
      r = v;
    end
    return r[TW-1:0];
  endfunction

  // phase set-up: wrap to the angle width, fold into the right half plane
  logic [2:0][CW-1:0] phase, phase_f;
  logic [2:0]         flip;

  for (genvar a = 0; a < 3; a++) begin : g_prep
    assign phase[a]   = {{(CW-ANGLE_W){angle_i[a][ANGLE_W-1]}}, angle_i[a]}
                        << (CW - ANGLE_BITS);
    assign flip[a]    = phase[a][CW-1] ^ phase[a][CW-2];
    assign phase_f[a] = phase[a] ^ {flip[a], {(CW-1){1'b0}}};
  end

  // iteration stages
  logic signed [CW-1:0] x_q [CORDIC_STEPS][3];
  logic signed [CW-1:0] y_q [CORDIC_STEPS][3];
  logic signed [CW-1:0] z_q [CORDIC_STEPS][3];
  logic signed [CW-1:0] x_d [CORDIC_STEPS][3];
  logic signed [CW-1:0] y_d [CORDIC_STEPS][3];
  logic signed [CW-1:0] z_d [CORDIC_STEPS][3];
  logic [2:0]           flp_q [CORDIC_STEPS];
  shifts_t              shf_q [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] vld_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [CW-1:0] ATAN = ATAN_TURN[i];
    for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [CW-1:0] x_s, y_s, z_s;
      if (i == 0) begin : g_first
        assign x_s = CW'(CORDIC_GAIN_Q30);
        assign y_s = '0;
        assign z_s = $signed(phase_f[a]);
      end else begin : g_next
        assign x_s = x_q[i-1][a];
        assign y_s = y_q[i-1][a];
        assign z_s = z_q[i-1][a];
      end
      // rotate towards zero residual phase
      assign x_d[i][a] = z_s[CW-1] ? x_s + (y_s >>> i) : x_s - (y_s >>> i);
      assign y_d[i][a] = z_s[CW-1] ? y_s - (x_s >>> i) : y_s + (x_s >>> i);
      assign z_d[i][a] = z_s[CW-1] ? z_s + ATAN : z_s - ATAN;
    end
  end

  // stage payload, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
      flp_q[0] <= flip;
      shf_q[0] <= shf_i;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        flp_q[i] <= flp_q[i-1];
        shf_q[i] <= shf_q[i-1];
      end
    end
  end

  // valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CORDIC_STEPS-2:0], vld_i};
    end
  end

  // undo the fold, round half up and clamp
  logic [2:0][TW-1:0] sin_d, cos_d;

  for (genvar a = 0; a < 3; a++) begin : g_round
    logic signed [CW:0] xe, ye, xr, yr;
    assign xe = flp_q[L][a] ? -{x_q[L][a][CW-1], x_q[L][a]} : {x_q[L][a][CW-1], x_q[L][a]};
    assign ye = flp_q[L][a] ? -{y_q[L][a][CW-1], y_q[L][a]} : {y_q[L][a][CW-1], y_q[L][a]};
    assign xr = (xe + HALF) >>> SH;
    assign yr = (ye + HALF) >>> SH;
    assign cos_d[a] = clamp_trig(xr);
    assign sin_d[a] = clamp_trig(yr);
  end

  logic               vld_r_q;
  logic [2:0][TW-1:0] sin_q, cos_q;
  shifts_t            shf_r_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q   <= sin_d;
      cos_q   <= cos_d;
      shf_r_q <= shf_q[L];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_r_q <= 1'b0;
    end else if (en_i) begin
      vld_r_q <= vld_q[L];
    end
  end

  assign vld_o = vld_r_q;
  assign sin_o = sin_q;
  assign cos_o = cos_q;
  assign shf_o = shf_r_q;

endmodule

### hw/rtl/tbpt_matrix.sv
// matrix pipeline: pair products, pair rounding, triple products, sums and
// entry rounding with saturation; uses tbpt_pkg
module tbpt_matrix
  import tbpt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int TW = FRAC_BITS + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [2:0][TW-1:0] sin_i,
  input  logic [2:0][TW-1:0] cos_i,
  input  shifts_t            shf_i,
  output logic               vld_o,
  output result_t            res_o
);

  localparam int PW   = 2 * TW;
  localparam int SW   = PW + 1;
  localparam int SH2  = 2 * FRAC_BITS - OUT_FRAC;
  localparam int NSTG = 5;
  localparam logic signed [PW-1:0] ONE_P = 1;
  localparam logic signed [PW-1:0] HALFF = (ONE_P <<< FRAC_BITS) >>> 1;
  localparam logic signed [SW-1:0] ONE_S = 1;
  localparam logic signed [SW-1:0] HALFO = (ONE_S <<< SH2) >>> 1;
  localparam logic signed [SW-1:0] ELIM  = ONE_S <<< OUT_FRAC;

  function automatic logic signed [TW-1:0] rnd_pair(logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + HALFF) >>> FRAC_BITS;
    return t[TW-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] to_entry(logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + HALFO) >>> SH2;
    if (r > ELIM) begin
      r = ELIM;
    end else if (r < -ELIM) begin
      r = -ELIM;
    end
    return r[ENTRY_W-1:0];
  endfunction

  logic signed [TW-1:0] sx, sy, sz, cx, cy, cz;

  assign sx = $signed(sin_i[0]);
  assign sy = $signed(sin_i[1]);
  assign sz = $signed(sin_i[2]);
  assign cx = $signed(cos_i[0]);
  assign cy = $signed(cos_i[1]);
  assign cz = $signed(cos_i[2]);

  // stage registers
  logic signed [PW-1:0] m1_cycz_q, m1_cysz_q, m1_cysx_q, m1_cxcy_q, m1_cxsz_q;
  logic signed [PW-1:0] m1_sxsz_q, m1_czsx_q, m1_cxcz_q, m1_sxsy_q, m1_cxsy_q;
  logic signed [TW-1:0] m1_sy_q, m1_sz_q;
  logic signed [PW-1:0] pr_cycz_q, pr_cysz_q, pr_cysx_q, pr_cxcy_q, pr_cxsz_q;
  logic signed [PW-1:0] pr_sxsz_q, pr_czsx_q, pr_cxcz_q;
  logic signed [TW-1:0] pr_rczsx_q, pr_rcxcz_q, pr_rsxsy_q, pr_rcxsy_q, pr_sy_q, pr_sz_q;
  logic signed [PW-1:0] m2_cycz_q, m2_cysz_q, m2_cysx_q, m2_cxcy_q, m2_cxsz_q;
  logic signed [PW-1:0] m2_sxsz_q, m2_czsx_q, m2_cxcz_q;
  logic signed [PW-1:0] m2_q1_q, m2_q2_q, m2_q3_q, m2_q4_q;
  logic signed [TW-1:0] m2_sy_q;
  logic signed [SW-1:0] s1_d [N_ENTRY];
  logic signed [SW-1:0] s1_q [N_ENTRY];
  result_t              res_d, res_q;
  logic [NSTG-1:0]      vld_q;
  shifts_t              shf_q [NSTG-1];

  // sums with 2*frac fraction bits
  always_comb begin
    s1_d[0] = SW'(m2_cycz_q);
    s1_d[1] = SW'(m2_q1_q) + SW'(m2_cxsz_q);
    s1_d[2] = SW'(m2_sxsz_q) - SW'(m2_q2_q);
    s1_d[3] = -SW'(m2_cysz_q);
    s1_d[4] = SW'(m2_cxcz_q) - SW'(m2_q3_q);
    s1_d[5] = SW'(m2_czsx_q) + SW'(m2_q4_q);
    s1_d[6] = SW'(m2_sy_q) <<< FRAC_BITS;
    s1_d[7] = -SW'(m2_cysx_q);
    s1_d[8] = SW'(m2_cxcy_q);
  end

  // entry rounding and saturation
  always_comb begin
    res_d.shf = shf_q[NSTG-2];
    for (int k = 0; k < N_ENTRY; k++) begin
      res_d.ent[k] = to_entry(s1_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // pair products
      m1_cycz_q <= cy * cz;
      m1_cysz_q <= cy * sz;
      m1_cysx_q <= cy * sx;
      m1_cxcy_q <= cx * cy;
      m1_cxsz_q <= cx * sz;
      m1_sxsz_q <= sx * sz;
      m1_czsx_q <= cz * sx;
      m1_cxcz_q <= cx * cz;
      m1_sxsy_q <= sx * sy;
      m1_cxsy_q <= cx * sy;
      m1_sy_q   <= sy;
      m1_sz_q   <= sz;
      // pair rounding ahead of the third factor
      pr_cycz_q  <= m1_cycz_q;
      pr_cysz_q  <= m1_cysz_q;
      pr_cysx_q  <= m1_cysx_q;
      pr_cxcy_q  <= m1_cxcy_q;
      pr_cxsz_q  <= m1_cxsz_q;
      pr_sxsz_q  <= m1_sxsz_q;
      pr_czsx_q  <= m1_czsx_q;
      pr_cxcz_q  <= m1_cxcz_q;
      pr_rczsx_q <= rnd_pair(m1_czsx_q);
      pr_rcxcz_q <= rnd_pair(m1_cxcz_q);
      pr_rsxsy_q <= rnd_pair(m1_sxsy_q);
      pr_rcxsy_q <= rnd_pair(m1_cxsy_q);
      pr_sy_q    <= m1_sy_q;
      pr_sz_q    <= m1_sz_q;
      // triple products
      m2_cycz_q <= pr_cycz_q;
      m2_cysz_q <= pr_cysz_q;
      m2_cysx_q <= pr_cysx_q;
      m2_cxcy_q <= pr_cxcy_q;
      m2_cxsz_q <= pr_cxsz_q;
      m2_sxsz_q <= pr_sxsz_q;
      m2_czsx_q <= pr_czsx_q;
      m2_cxcz_q <= pr_cxcz_q;
      m2_q1_q   <= pr_rczsx_q * pr_sy_q;
      m2_q2_q   <= pr_rcxcz_q * pr_sy_q;
      m2_q3_q   <= pr_rsxsy_q * pr_sz_q;
      m2_q4_q   <= pr_rcxsy_q * pr_sz_q;
      m2_sy_q   <= pr_sy_q;
      // sums, then entries
      s1_q      <= s1_d;
      res_q     <= res_d;
      shf_q[0]  <= shf_i;
      for (int k = 1; k < NSTG - 1; k++) begin
        shf_q[k] <= shf_q[k-1];
      end
    end
  end

  // valid bits for the five stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], vld_i};
    end
  end

  assign vld_o = vld_q[NSTG-1];
  assign res_o = res_q;

endmodule

### hw/rtl/tbpt_skid.sv
// output register with a one-word skid stage; an empty skid stage advances the pipeline
// uses tbpt_pkg for the result word type
module tbpt_skid
  import tbpt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  result_t res_i,
  output logic    en_o,
  output logic    m_vld_o,
  output result_t m_res_o,
  input  logic    m_rdy_i
);

  logic    out_vld_q, out_vld_d, skd_vld_q, skd_vld_d;
  logic    out_ld, skd_ld, push, free;
  result_t out_q, out_d, skd_q;

  // the pipeline moves while the skid stage is empty
  assign en_o = !skd_vld_q;
  assign push = vld_i && !skd_vld_q;
  assign free = !out_vld_q || m_rdy_i;

  // next state of the two slots
  always_comb begin
    out_vld_d = out_vld_q;
    skd_vld_d = skd_vld_q;
    out_ld    = 1'b0;
    skd_ld    = 1'b0;
    out_d     = skd_vld_q ? skd_q : res_i;
    if (free) begin
      out_vld_d = skd_vld_q || push;
      out_ld    = 1'b1;
      skd_vld_d = 1'b0;
    end else if (push) begin
      skd_vld_d = 1'b1;
      skd_ld    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  // word storage, no reset
  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_q <= out_d;
    end
    if (skd_ld) begin
      skd_q <= res_i;
    end
  end

  assign m_vld_o = out_vld_q;
  assign m_res_o = out_q;

endmodule

### tb/tb_tait_bryan_pose_to_transform_unit.sv
// self-checking bench for tait_bryan_pose_to_transform_unit: poses in, rotation plus shift out
// predicts each transform with its own fixed-point cordic and matrix maths; uses tbpt_pkg types
module tb_tait_bryan_pose_to_transform_unit
  import tbpt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CLK_PERIOD      = 12;
  localparam int  RESET_CYCLES    = 12;
  localparam int  PIPE_LATENCY    = 36;
  localparam int  PHASE_POSES     = 425;
  localparam int  CYCLE_LIMIT     = 400000;
  localparam int  DRAIN_LIMIT     = 20000;
  localparam int  PRINT_LIMIT     = 50;
  localparam int  SC_FRAC         = 14;
  localparam int  SC_STEPS        = 30;
  localparam longint CORDIC_X0    = 652032874;
  localparam longint UNIT_ONE     = 64'sd16384;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ARC_TURN [SC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // one pose as it travels on s_axis
  typedef struct {
    logic [ANGLE_W-1:0] ang_x;
    logic [ANGLE_W-1:0] ang_y;
    logic [ANGLE_W-1:0] ang_z;
    logic [SHIFT_W-1:0] shift_x;
    logic [SHIFT_W-1:0] shift_y;
    logic [SHIFT_W-1:0] shift_z;
  } pose_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // angle_x, angle_y, angle_z, shift_x, shift_y, shift_z
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // r_row0_col0 .. r_row2_col2 column by column, out_shift_x, out_shift_y, out_shift_z
  logic [OUT_W-1:0] m_axis_tdata;

  result_t transform_q [$];
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      poses_sent = 0;
  int      words_checked = 0;
  int      mismatch_count = 0;
  int      cycle_count = 0;

  tait_bryan_pose_to_transform_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // fixed-point prediction
  // ---------------------------------------------------------------------------

  // round half up: floor((v + half) / 2^sh)
  function automatic longint round_off(input longint v, input int sh);
    longint half;
    half = 64'sd1 <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  function automatic longint limit_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // sine and cosine of one binary angle, FRAC_BITS fraction bits
  function automatic void cordic_sin_cos(input logic [ANGLE_W-1:0] ang,
                                         output longint s, output longint c);
    logic [31:0] phase;
    logic        flip;
    longint      x, y, z, nx, ny;
    x = CORDIC_X0;
    y = 0;
    phase = {ang, 16'h0000};
    // second and third quadrant: rotate by half a turn, negate afterwards
    flip = phase[31] ^ phase[30];
    if (flip) phase[31] = ~phase[31];
    z = longint'($signed(phase));
    for (int i = 0; i < SC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - longint'(ARC_TURN[i]);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + longint'(ARC_TURN[i]);
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = limit_mag(round_off(x, 30 - SC_FRAC), UNIT_ONE);
    s = limit_mag(round_off(y, 30 - SC_FRAC), UNIT_ONE);
  endfunction

  // product of two unit values brought back to unit scale
  function automatic longint pair_mul(input longint a, input longint b);
    return round_off(a * b, SC_FRAC);
  endfunction

  // rotation R = Rx*Ry*Rz and the translation carried along
  function automatic result_t predict_transform(input pose_t p);
    longint  sx, cx, sy, cy, sz, cz;
    longint  acc [N_ENTRY];
    result_t r;
    cordic_sin_cos(p.ang_x, sx, cx);
    cordic_sin_cos(p.ang_y, sy, cy);
    cordic_sin_cos(p.ang_z, sz, cz);
    acc[0] = cy * cz;
    acc[1] = pair_mul(cz, sx) * sy + cx * sz;
    acc[2] = -pair_mul(cx, cz) * sy + sx * sz;
    acc[3] = -(cy * sz);
    acc[4] = cx * cz - pair_mul(sx, sy) * sz;
    acc[5] = cz * sx + pair_mul(cx, sy) * sz;
    acc[6] = sy * UNIT_ONE;
    acc[7] = -(cy * sx);
    acc[8] = cx * cy;
    // entries carry 2*FRAC bits here; round to q1.14 and saturate at one
    for (int k = 0; k < N_ENTRY; k++) begin
      r.ent[k] = ENTRY_W'(limit_mag(round_off(acc[k], 2 * SC_FRAC - OUT_FRAC),
                                    longint'(ENTRY_MAX)));
    end
    r.shf.x = p.shift_x;
    r.shf.y = p.shift_y;
    r.shf.z = p.shift_z;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pose_t make_pose(input logic [15:0] ax, input logic [15:0] ay,
                                      input logic [15:0] az, input logic [31:0] tx,
                                      input logic [31:0] ty, input logic [31:0] tz);
    pose_t p;
    p.ang_x = ax;
    p.ang_y = ay;
    p.ang_z = az;
    p.shift_x = tx;
    p.shift_y = ty;
    p.shift_z = tz;
    return p;
  endfunction

  // mix of arbitrary angles, angles close to eighth turns and small angles
  function automatic logic [15:0] random_angle();
    logic [15:0] a;
    case ($urandom_range(2))
      0: a = 16'($urandom);
      1: a = 16'($urandom_range(7) * 8192) + 16'($urandom_range(8)) - 16'd4;
      default: a = 16'($urandom_range(255)) - 16'd128;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] random_shift();
    logic [31:0] v;
    case ($urandom_range(15))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'hFFFF_FFFF;
      3: v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // send one pose word, optionally after an idle gap, and log what it must give
  task automatic send_pose(input pose_t p);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.shift_z, p.shift_y, p.shift_x, p.ang_z, p.ang_y, p.ang_x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    transform_q.push_back(predict_transform(p));
    poses_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  // random back-pressure on the result stream
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // compare every accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (transform_q.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing pending", words_checked));
      end else begin
        want = transform_q.pop_front();
        for (int k = 0; k < N_ENTRY; k++) begin
          if (got.ent[k] !== want.ent[k])
            report_mismatch($sformatf("word %0d r_row%0d_col%0d got %0d expected %0d",
                                      words_checked, k % 3, k / 3,
                                      $signed(got.ent[k]), $signed(want.ent[k])));
        end
        if (got.shf.x !== want.shf.x)
          report_mismatch($sformatf("word %0d out_shift_x got %h expected %h",
                                    words_checked, got.shf.x, want.shf.x));
        if (got.shf.y !== want.shf.y)
          report_mismatch($sformatf("word %0d out_shift_y got %h expected %h",
                                    words_checked, got.shf.y, want.shf.y));
        if (got.shf.z !== want.shf.z)
          report_mismatch($sformatf("word %0d out_shift_z got %h expected %h",
                                    words_checked, got.shf.z, want.shf.z));
      end
      words_checked++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // quarter turns, a half turn and an eighth turn about each axis alone;
  // a quarter turn about y is the gimbal-lock case
  task automatic test_single_axis();
    logic [15:0] turns [4];
    turns = '{16'h4000, 16'h8000, 16'hC000, 16'h2000};
    for (int t = 0; t < 4; t++) begin
      send_pose(make_pose(turns[t], 16'h0, 16'h0, 32'h0001_0000, 32'h0, 32'h0));
      send_pose(make_pose(16'h0, turns[t], 16'h0, 32'h0, 32'h0001_0000, 32'h0));
      send_pose(make_pose(16'h0, 16'h0, turns[t], 32'h0, 32'h0, 32'h0001_0000));
    end
  endtask

  // angles on either side of the quadrant folds, plus the extreme codes
  task automatic test_quadrant_edges();
    logic [15:0] edge_ang [7];
    edge_ang = '{16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001, 16'h7FFF, 16'h0001, 16'hFFFF};
    for (int t = 0; t < 7; t++)
      send_pose(make_pose(edge_ang[t], edge_ang[(t + 1) % 7], edge_ang[(t + 3) % 7],
                          $urandom, $urandom, $urandom));
  endtask

  // zero rotation (cosines at full scale) and half-turn angles, with extreme translations
  task automatic test_translation_extremes();
    send_pose(make_pose(16'h0, 16'h0, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_pose(make_pose(16'h0, 16'h0, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
    send_pose(make_pose(16'h8000, 16'h8000, 16'h8000,
                        32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000));
    send_pose(make_pose(16'h7FFF, 16'h8000, 16'h7FFF,
                        32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
  endtask

  // random poses streamed under one idling pattern
  task automatic test_random_stream(input int gap_pct, input int hold_pct, input int count);
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    for (int n = 0; n < count; n++)
      send_pose(make_pose(random_angle(), random_angle(), random_angle(),
                          random_shift(), random_shift(), random_shift()));
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    int drain;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_axis();
    test_quadrant_edges();
    test_translation_extremes();
    test_random_stream(0, 0, PHASE_POSES);
    test_random_stream(79, 0, PHASE_POSES);
    test_random_stream(0, 79, PHASE_POSES);
    test_random_stream(8, 8, PHASE_POSES);
    s_axis_tvalid <= 1'b0;

    // let the pipeline empty, then watch for stray words
    drain = 0;
    while (transform_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    if (transform_q.size() != 0)
      report_mismatch($sformatf("%0d transforms never arrived", transform_q.size()));
    repeat (PIPE_LATENCY + 8) @(posedge clk_i);

    $display("%0d poses sent, %0d transforms checked: single-axis turns, quadrant folds,",
             poses_sent, words_checked);
    $display("extreme shifts and random poses under four idle and stall patterns");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
